// ----- hdl/sparse_polynomial_adder_defines.svh -----
// ----------------------------------------------------------------------------
// sparse_polynomial_adder_defines
// Assertion macros used by the sparse polynomial adder datapath.
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_ADDER_DEFINES_SVH
`define SPARSE_POLYNOMIAL_ADDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spa assertion failed");

// Next-cycle implication, disabled during reset.
`define SPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spa assertion failed");

`endif

// ----- hdl/spa_pkg.sv -----
// ----------------------------------------------------------------------------
// spa_pkg
// Types and codes shared by the sparse polynomial adder modules.
// ----------------------------------------------------------------------------
package spa_pkg;

    localparam logic [1:0] OP_APPEND_A = 2'd0;
    localparam logic [1:0] OP_APPEND_B = 2'd1;
    localparam logic [1:0] OP_MERGE    = 2'd2;

    typedef struct packed {
        logic [1:0]          op;
        logic signed [15:0]  in_coeff;
        logic [9:0]          in_power;
    } t_in_item;

    typedef struct packed {
        logic signed [16:0]  out_coeff;
        logic [9:0]          out_power;
        logic                has_term;
        logic                dropped;
        logic                last;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0]  coeff;
        logic [9:0]          power;
    } t_term;

    typedef enum logic {
        S_LOAD,
        S_MERGE
    } t_state;

    typedef struct packed {
        logic push_a;
        logic push_b;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic last_step;
    } t_sts;

endpackage

// ----- hdl/sparse_polynomial_adder.sv -----
// ----------------------------------------------------------------------------
// sparse_polynomial_adder
// Adds two sparse polynomials held as term lists by a head-by-head merge.
// ----------------------------------------------------------------------------
// Append items (op 0 to A, op 1 to B) are taken one per cycle while loading;
// a term that finds its list full is dropped and flagged on the next merge.
// A merge item (op 2) makes the block walk both lists with one shared
// compare-and-add step, one sum term per cycle while the output is free;
// terms of matching power are added into one sum term, and an empty sum
// gives one item with no term. No input item is taken during the merge.
// Sum terms leave through a registered output, so a stalled result holds
// only the merge, and appends resume once it ends. Op 3 is taken and ignored.
module sparse_polynomial_adder #(
    parameter int TERMS_PER_POLY = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  spa_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output spa_pkg::t_out_item o_out_item
);

    spa_pkg::t_cmd cmd;
    spa_pkg::t_sts sts;

    spa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_in_item.op),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    spa_dpath #(
        .TERMS_PER_POLY (TERMS_PER_POLY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in_item),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ----- hdl/spa_ctrl.sv -----
// ----------------------------------------------------------------------------
// spa_ctrl
// Controller: takes items while loading, sequences the merge one term a cycle while the output is free.
// ----------------------------------------------------------------------------
module spa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_op,
    input  spa_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output spa_pkg::t_cmd o_cmd
);

    spa_pkg::t_state r_state;
    spa_pkg::t_state n_state;
    logic            accept;

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spa_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            spa_pkg::S_LOAD: begin
                if (accept && i_op == spa_pkg::OP_MERGE) begin
                    n_state = spa_pkg::S_MERGE;
                end
            end
            spa_pkg::S_MERGE: begin
                if (i_sts.out_free && i_sts.last_step) begin
                    n_state = spa_pkg::S_LOAD;
                end
            end
            default: n_state = spa_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            spa_pkg::S_LOAD: begin
                o_in_ready   = 1'b1;
                o_cmd.push_a = i_in_valid && i_op == spa_pkg::OP_APPEND_A;
                o_cmd.push_b = i_in_valid && i_op == spa_pkg::OP_APPEND_B;
            end
            spa_pkg::S_MERGE: begin
                o_cmd.step = i_sts.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

// ----- hdl/spa_dpath.sv -----
// ----------------------------------------------------------------------------
// spa_dpath
// Datapath: term stores, counts, merge indices, compare/add and output item.
// ----------------------------------------------------------------------------
`include "sparse_polynomial_adder_defines.svh"

module spa_dpath #(
    parameter int TERMS_PER_POLY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spa_pkg::t_in_item i_item,
    input  spa_pkg::t_cmd     i_cmd,
    output spa_pkg::t_sts     o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spa_pkg::t_out_item o_out_item
);

    localparam int CNT_W = $clog2(TERMS_PER_POLY + 1);
    localparam int IDX_W = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(TERMS_PER_POLY);

    spa_pkg::t_term     r_mem_a [TERMS_PER_POLY];
    spa_pkg::t_term     r_mem_b [TERMS_PER_POLY];
    logic [CNT_W-1:0]   r_cnt_a;
    logic [CNT_W-1:0]   r_cnt_b;
    logic [CNT_W-1:0]   r_ia;
    logic [CNT_W-1:0]   r_ib;
    logic               r_overflow;
    logic               r_out_valid;
    spa_pkg::t_out_item r_out;

    spa_pkg::t_term     term_a;
    spa_pkg::t_term     term_b;
    spa_pkg::t_term     new_term;
    logic               a_ok;
    logic               b_ok;
    logic               take_a;
    logic               take_b;
    logic               room_a;
    logic               room_b;
    logic signed [16:0] add_a;
    logic signed [16:0] add_b;
    logic [CNT_W-1:0]   n_ia;
    logic [CNT_W-1:0]   n_ib;
    logic               last_step;
    spa_pkg::t_out_item n_out;

    assign new_term = '{coeff: i_item.in_coeff, power: i_item.in_power};
    assign room_a   = r_cnt_a < CAP;
    assign room_b   = r_cnt_b < CAP;

    assign term_a = r_mem_a[r_ia[IDX_W-1:0]];
    assign term_b = r_mem_b[r_ib[IDX_W-1:0]];
    assign a_ok   = r_ia < r_cnt_a;
    assign b_ok   = r_ib < r_cnt_b;

    always_comb begin
        take_a = 1'b0;
        take_b = 1'b0;
        priority if (a_ok && b_ok) begin
            take_a = term_a.power >= term_b.power;
            take_b = term_a.power <= term_b.power;
        end else if (a_ok) begin
            take_a = 1'b1;
        end else if (b_ok) begin
            take_b = 1'b1;
        end else begin
            take_a = 1'b0;
        end
    end

    assign add_a = take_a ? {term_a.coeff[15], term_a.coeff} : '0;
    assign add_b = take_b ? {term_b.coeff[15], term_b.coeff} : '0;
    assign n_ia  = r_ia + CNT_W'(take_a);
    assign n_ib  = r_ib + CNT_W'(take_b);
    assign last_step = (n_ia >= r_cnt_a) && (n_ib >= r_cnt_b);

    always_comb begin
        n_out.out_coeff = add_a + add_b;
        n_out.out_power = take_a ? term_a.power : (take_b ? term_b.power : '0);
        n_out.has_term  = take_a || take_b;
        n_out.dropped   = r_overflow;
        n_out.last      = last_step;
    end

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.last_step = last_step;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_a && room_a) begin
            r_mem_a[r_cnt_a[IDX_W-1:0]] <= new_term;
        end
        if (i_cmd.push_b && room_b) begin
            r_mem_b[r_cnt_b[IDX_W-1:0]] <= new_term;
        end
        if (i_cmd.step) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.push_a) begin
                if (room_a) begin
                    r_cnt_a <= r_cnt_a + CNT_W'(1);
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            if (i_cmd.push_b) begin
                if (room_b) begin
                    r_cnt_b <= r_cnt_b + CNT_W'(1);
                end else begin
                    r_overflow <= 1'b1;
                end
            end
            if (i_cmd.step) begin
                r_out_valid <= 1'b1;
                if (last_step) begin
                    r_ia       <= '0;
                    r_ib       <= '0;
                    r_cnt_a    <= '0;
                    r_cnt_b    <= '0;
                    r_overflow <= 1'b0;
                end else begin
                    r_ia <= n_ia;
                    r_ib <= n_ib;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `SPA_ASSERT_IMP(a_spa_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt_a <= CAP && r_cnt_b <= CAP)
    `SPA_ASSERT_IMP(a_spa_idx_bound, i_clk, i_rst_n, 1'b1, r_ia <= r_cnt_a && r_ib <= r_cnt_b)
    `SPA_ASSERT_IMP(a_spa_step_room, i_clk, i_rst_n, i_cmd.step, o_sts.out_free)
    `SPA_ASSERT_NXT(a_spa_clear, i_clk, i_rst_n, i_cmd.step && last_step, r_cnt_a == '0 && r_cnt_b == '0 && !r_overflow && r_out_valid)

endmodule
